// ===== hdl/vlrd_pkg.sv =====
// Shared types and constants for the velocity limit, ramp and deadband block.
`default_nettype none
package vlrd_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned REQ_W      = 13;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned MAXV_W     = 11;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic [REQ_W-1:0]  REQ_THRESHOLD = 13'd1229;
  localparam logic [MAXV_W-1:0] SPEED_CAP     = 11'd1638;
  // floor(d * 1311 / 2^16) == floor(d / 50) for every d below 2048
  localparam logic [MAXV_W-1:0] RECIP_50      = 11'd1311;
  localparam logic [VEL_W-1:0]  BONUS_STEP    = 16'd41;
  localparam logic signed [VEL_W-1:0] DEADBAND = 16'sd328;

  localparam int unsigned   ITER_STEPS = 16;
  localparam int unsigned   ITER_W     = $clog2(ITER_STEPS);
  localparam logic [31:0]   SQRT_BIT0  = 32'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_LSQ,
    ST_CMP,
    ST_SQRT,
    ST_MULX,
    ST_MULY,
    ST_DINIT,
    ST_DIV,
    ST_FIN
  } vlrd_state_t;

  typedef struct packed {
    logic load;       // capture a velocity command and step the ramp
    logic count;      // store a people count
    logic sq_x;
    logic sq_y;
    logic lim_sq;
    logic cmp;        // latch the over-limit flag and seed the square root
    logic sqrt_step;
    logic mul_x;
    logic mul_y;
    logic div_init;
    logic div_step;
    logic out_load;
  } vlrd_cmd_t;

  typedef struct packed {
    logic over;
    logic out_busy;
  } vlrd_sts_t;

endpackage
`default_nettype wire

// ===== hdl/velocity_limit_ramp_deadband.sv =====
// Velocity limiter with speed ramp and angular deadband: top level and register port.
//
// Input stream s_*: one transaction per item. s_tuser = 0 is a velocity command,
// s_tuser = 1 a people-count update that only stores the count and gives no result.
// Output stream m_*: one transaction per velocity command, in order.
// Register 0 (byte address 0) holds max_speed_request; write it only while idle.
//
// A command whose x,y magnitude is within the limit runs only the square and compare
// steps; one that must be scaled also runs the 16-step square root followed by the
// 16-step dividers (both axes in parallel) around one shared 16x16 multiplier.
// A people-count item is stored without leaving the idle state.
// Items are processed one at a time; s_tready is high only between items, so a new
// item is taken only once the previous command has reached the output register.
// A finished result waits in the output register while the next item is taken.
// If m_tready stays low, the next result waits in its final step and no further
// item is accepted until the output register drains.
// Synchronous reset clears the register, the ramp state and the output valid.
`default_nettype none
module velocity_limit_ramp_deadband (
  input  wire logic         clk,
  input  wire logic         rst,
  // APB register port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // lin_x[15:0], lin_y[31:16], lin_z[47:32], ang_x[63:48], ang_y[79:64],
  // ang_z[95:80], people_count[102:96], zero[103]
  input  wire logic [103:0] s_tdata,
  // action[0]
  input  wire logic         s_tuser,
  // output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_lin_x[15:0], out_lin_y[31:16], out_lin_z[47:32], out_ang_x[63:48],
  // out_ang_y[79:64], out_ang_z[95:80]
  output logic [95:0]       m_tdata
);
  import vlrd_pkg::*;

  localparam logic REG_MAX_SPEED = 1'b0;

  logic [REQ_W-1:0] max_speed_request;
  vlrd_cmd_t        cmd;
  vlrd_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed_request <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_SPEED) begin
      max_speed_request <= pwdata[REQ_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_SPEED) ? {{(32-REQ_W){1'b0}}, max_speed_request}
                                              : '0;

  vlrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vlrd_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .max_speed_request (max_speed_request),
    .s_tdata           (s_tdata),
    .cmd               (cmd),
    .sts               (sts),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/vlrd_div.sv =====
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle while step is high.
`default_nettype none
module vlrd_div (
  input  wire logic        clk,
  input  wire logic        init,
  input  wire logic        step,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic      [15:0] quotient
);
  // the upper half of the dividend is always below the divisor, so 16 bits suffice
  logic [15:0] rem;
  logic [15:0] low;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem, low[15]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (init) begin
      rem <= dividend[31:16];
      low <= dividend[15:0];
    end else if (step) begin
      if (!diff[16]) begin
        rem <= diff[15:0];
        low <= {low[14:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        low <= {low[14:0], 1'b0};
      end
    end
  end

  assign quotient = low;

endmodule
`default_nettype wire

// ===== hdl/vlrd_datapath.sv =====
// Datapath: ramp state, shared multiplier, square root, two dividers and output register.
`default_nettype none
module vlrd_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [vlrd_pkg::REQ_W-1:0]     max_speed_request,
  input  wire logic [vlrd_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire vlrd_pkg::vlrd_cmd_t            cmd,
  output vlrd_pkg::vlrd_sts_t                 sts,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [vlrd_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import vlrd_pkg::*;

  // ramp state
  logic [CNT_W-1:0] people_seen;
  logic             ramp_started;
  logic [VEL_W-1:0] ramp_limit;
  logic [VEL_W-1:0] ramp_bonus;

  // captured command
  logic signed [VEL_W-1:0] in_x, in_y, in_z, in_ax, in_ay, in_az;
  logic [VEL_W-1:0]        abs_x, abs_y;
  logic                    limited;

  // arithmetic registers
  logic [31:0] prod;
  logic [31:0] prod_x;
  logic [31:0] ssum;
  logic [31:0] sq_rem;
  logic [31:0] sq_root;
  logic [31:0] sq_bit;

  // ramp update
  logic [MAXV_W-1:0]   maxv;
  logic [VEL_W-1:0]    lim0;
  logic [MAXV_W-1:0]   ramp_gap;
  logic [2*MAXV_W-1:0] gap_scaled;
  logic [VEL_W+1:0]    lim_sum;
  logic [VEL_W:0]      bonus_sum;
  logic                climb;

  assign maxv       = (max_speed_request >= REQ_THRESHOLD) ? SPEED_CAP
                                                           : max_speed_request[MAXV_W-1:0];
  assign lim0       = ramp_started ? ramp_limit : {{(VEL_W-MAXV_W){1'b0}}, maxv};
  assign climb      = lim0 < {{(VEL_W-MAXV_W){1'b0}}, maxv};
  assign ramp_gap   = maxv - lim0[MAXV_W-1:0];
  assign gap_scaled = ramp_gap * RECIP_50;
  assign lim_sum    = {2'b00, lim0} + {{(VEL_W+2-(2*MAXV_W-16)){1'b0}},
                                        gap_scaled[2*MAXV_W-1:16]}
                      + {2'b00, ramp_bonus};
  assign bonus_sum  = {1'b0, ramp_bonus} + {1'b0, BONUS_STEP};

  always_ff @(posedge clk) begin
    if (rst) begin
      people_seen  <= '0;
      ramp_started <= 1'b0;
      ramp_limit   <= '0;
      ramp_bonus   <= '0;
    end else if (cmd.count) begin
      people_seen <= s_tdata[6*VEL_W +: CNT_W];
    end else if (cmd.load) begin
      if (people_seen == '0) begin
        ramp_started <= 1'b1;
        if (climb) begin
          ramp_limit <= (lim_sum[VEL_W+1:VEL_W] != 2'b00) ? '1 : lim_sum[VEL_W-1:0];
          ramp_bonus <= bonus_sum[VEL_W] ? '1 : bonus_sum[VEL_W-1:0];
        end else begin
          ramp_limit <= lim0;
        end
      end else begin
        ramp_limit <= {{(VEL_W-MAXV_W){1'b0}}, maxv};
      end
    end
  end

  // capture the command fields
  logic signed [VEL_W-1:0] new_x, new_y;
  assign new_x = s_tdata[0 +: VEL_W];
  assign new_y = s_tdata[VEL_W +: VEL_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_x  <= new_x;
      in_y  <= new_y;
      in_z  <= s_tdata[2*VEL_W +: VEL_W];
      in_ax <= s_tdata[3*VEL_W +: VEL_W];
      in_ay <= s_tdata[4*VEL_W +: VEL_W];
      in_az <= s_tdata[5*VEL_W +: VEL_W];
      abs_x <= new_x[VEL_W-1] ? VEL_W'(-new_x) : new_x;
      abs_y <= new_y[VEL_W-1] ? VEL_W'(-new_y) : new_y;
    end
  end

  // shared multiplier
  logic [VEL_W-1:0] mul_a, mul_b;
  logic [31:0]      mul_p;

  always_comb begin
    mul_a = abs_x;
    mul_b = abs_x;
    if (cmd.sq_y) begin
      mul_a = abs_y;
      mul_b = abs_y;
    end else if (cmd.lim_sq) begin
      mul_a = ramp_limit;
      mul_b = ramp_limit;
    end else if (cmd.mul_x) begin
      mul_a = abs_x;
      mul_b = ramp_limit;
    end else if (cmd.mul_y) begin
      mul_a = abs_y;
      mul_b = ramp_limit;
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.sq_x || cmd.sq_y || cmd.lim_sq || cmd.mul_x || cmd.mul_y) begin
      prod <= mul_p;
    end
    if (cmd.sq_y) begin
      ssum <= prod;
    end else if (cmd.lim_sq) begin
      ssum <= ssum + prod;
    end
    if (cmd.mul_y) begin
      prod_x <= prod;
    end
  end

  // x*x + y*y against limit*limit
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      limited <= ssum > prod;
    end
  end

  // integer square root, one result bit per step
  logic [32:0] sq_trial;
  assign sq_trial = {1'b0, sq_root} + {1'b0, sq_bit};

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      sq_rem  <= ssum;
      sq_root <= '0;
      sq_bit  <= SQRT_BIT0;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, sq_rem} >= sq_trial) begin
        sq_rem  <= sq_rem - sq_trial[31:0];
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // scale both axes by limit / magnitude
  logic [VEL_W-1:0] quo_x, quo_y;

  vlrd_div u_div_x (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .dividend (prod_x),
    .divisor  (sq_root[VEL_W-1:0]),
    .quotient (quo_x)
  );

  vlrd_div u_div_y (
    .clk      (clk),
    .init     (cmd.div_init),
    .step     (cmd.div_step),
    .dividend (prod),
    .divisor  (sq_root[VEL_W-1:0]),
    .quotient (quo_y)
  );

  // output register
  logic [VEL_W-1:0] res_x, res_y, res_az;

  assign res_x  = !limited ? in_x : (in_x[VEL_W-1] ? VEL_W'(-quo_x) : quo_x);
  assign res_y  = !limited ? in_y : (in_y[VEL_W-1] ? VEL_W'(-quo_y) : quo_y);
  assign res_az = (in_az < DEADBAND && in_az > -DEADBAND) ? '0 : in_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {res_az, in_ay, in_ax, in_z, res_y, res_x};
    end
  end

  assign sts.over     = ssum > prod;
  assign sts.out_busy = m_tvalid && !m_tready;

  a_scaled_not_larger: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && limited) |-> (quo_x <= abs_x && quo_y <= abs_y))
    else $error("scaled velocity exceeds its input");

  a_bonus_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (ramp_bonus >= $past(ramp_bonus)))
    else $error("ramp bonus decreased");

endmodule
`default_nettype wire

// ===== hdl/vlrd_ctrl.sv =====
// Controller: sequences the multiplier, square root and divider steps for each command.
`default_nettype none
module vlrd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                s_tuser,
  output logic                     s_tready,
  input  wire vlrd_pkg::vlrd_sts_t sts,
  output vlrd_pkg::vlrd_cmd_t      cmd
);
  import vlrd_pkg::*;

  vlrd_state_t       state, state_next;
  logic [ITER_W-1:0] iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser) begin
            cmd.count = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = ST_SQX;
          end
        end
      end
      ST_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = ST_LSQ;
      end
      ST_LSQ: begin
        cmd.lim_sq = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        iter_next  = '0;
        state_next = sts.over ? ST_SQRT : ST_FIN;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_next     = iter + 1'b1;
        if (iter == ITER_W'(ITER_STEPS - 1)) begin
          state_next = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MULY;
      end
      ST_MULY: begin
        cmd.mul_y  = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        iter_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + 1'b1;
        if (iter == ITER_W'(ITER_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a pending transaction");

endmodule
`default_nettype wire
